// ===== rtl/rcv_pkg.sv =====
// ----------------------------------------------------------------------------
// rcv_pkg
// Shared types and constants for the record checksum validator.
// ----------------------------------------------------------------------------
package rcv_pkg;

  localparam int unsigned MAX_NAME_BYTES   = 32;
  localparam int unsigned MAX_ACTUATOR_IDS = 16;
  localparam int unsigned MAX_BUTTON_IDS   = 16;

  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned SUM_BYTES = 4;
  localparam int unsigned MIN_LEN   = HDR_BYTES + SUM_BYTES;

  localparam logic [7:0]  REC_VERSION = 8'd2;
  localparam logic [31:0] FNV_BASIS   = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME   = 32'd16777619;
  localparam logic [7:0]  COUNT_MAX   = 8'hFF;

  // seen-ID maps: one row holds eight ID bits; top address bit picks the list
  localparam int unsigned MAP_ROW_BITS = 8;
  localparam int unsigned MAP_ROWS     = 64;

  typedef enum logic [2:0] {
    KIND_HDR  = 3'd0,
    KIND_NAME = 3'd1,
    KIND_ACT  = 3'd2,
    KIND_BTN  = 3'd3,
    KIND_TAIL = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_LEN      = 4'd1,
    ST_MAGIC    = 4'd2,
    ST_VERSION  = 4'd3,
    ST_NAME_LEN = 4'd4,
    ST_COUNT    = 4'd5,
    ST_MISMATCH = 4'd6,
    ST_CHECKSUM = 4'd7,
    ST_ZERO_ID  = 4'd8,
    ST_DUP_ID   = 4'd9
  } status_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h4C; // L
      2'd1:    b = 8'h53; // S
      2'd2:    b = 8'h48; // H
      default: b = 8'h44; // D
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/rcv_ifs.sv =====
// ----------------------------------------------------------------------------
// rcv_ifs
// Valid/ready channel interfaces for the record byte stream and results.
// ----------------------------------------------------------------------------
interface rcv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rcv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [2:0] byte_kind;
  logic       record_done;
  logic [3:0] status;

  modport source (output valid, output byte_value, output byte_kind, output record_done,
                  output status, input ready);
  modport sink   (input valid, input byte_value, input byte_kind, input record_done,
                  input status, output ready);
endinterface

// ===== rtl/rcv_ram.sv =====
// ----------------------------------------------------------------------------
// rcv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/record_checksum_validator_unit.sv =====
// Bytes pass the stage 1 and output registers; one byte per cycle while out_stream.ready holds.
// Stage 0 updates the header state and the FNV-1a hash and reads the seen-ID map row;
// stage 1 tests and writes back the ID bit (with forwarding) and settles the status.
// Reset (synchronous, active low) clears all record state; the ID maps are emptied at
// once through per-row valid bits, here and at the end of every record, with no sweep.
// ----------------------------------------------------------------------------
// record_checksum_validator_unit
// Framed record validator: tags each byte by section, checks header, length,
// FNV-1a-32 checksum and ID lists, and reports a status on the last byte.
// ----------------------------------------------------------------------------
module record_checksum_validator_unit #(
  parameter int unsigned MAX_NAME_BYTES   = rcv_pkg::MAX_NAME_BYTES,
  parameter int unsigned MAX_ACTUATOR_IDS = rcv_pkg::MAX_ACTUATOR_IDS,
  parameter int unsigned MAX_BUTTON_IDS   = rcv_pkg::MAX_BUTTON_IDS
) (
  input  logic             clk,
  input  logic             rst_n,
  rcv_in_if.sink           in_stream,
  rcv_out_if.source        out_stream
);

  localparam int unsigned MAP_AW  = $clog2(rcv_pkg::MAP_ROWS);
  localparam int unsigned BIT_AW  = $clog2(rcv_pkg::MAP_ROW_BITS);
  localparam int unsigned MAX_LEN = rcv_pkg::HDR_BYTES + MAX_NAME_BYTES + MAX_ACTUATOR_IDS +
                                    MAX_BUTTON_IDS + rcv_pkg::SUM_BYTES;

  typedef struct packed {
    logic [7:0]          byte_value;
    rcv_pkg::kind_t      kind;
    logic                last;
    rcv_pkg::status_t    pre_status;
    logic [31:0]         hash;
    logic [31:0]         stored;
    logic                is_id;
    logic [MAP_AW-1:0]   row;
    logic [BIT_AW-1:0]   bit_sel;
    logic                id_zero;
  } p1_t;

  // ---------------- stage 0 state ----------------
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic        magic_bad_r, magic_bad_nxt;
  logic [7:0]  version_r, version_nxt;
  logic [7:0]  name_len_r, name_len_nxt;
  logic [7:0]  act_cnt_r, act_cnt_nxt;
  logic [7:0]  btn_cnt_r, btn_cnt_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [7:0]  tail_r [4];
  logic [7:0]  tail_nxt [4];
  logic        overlong_r, overlong_nxt;

  logic        accept;
  logic        in_ready;
  logic        adv;
  logic [9:0]  pos10;
  logic [9:0]  a0, b0, c0;
  logic [9:0]  expect_len;
  logic [31:0] hash_mul;
  logic [31:0] hash_upd;
  rcv_pkg::kind_t   kind0;
  rcv_pkg::status_t pre_status0;
  logic [31:0] stored0;

  // ---------------- stage 1 state ----------------
  p1_t         p1_r;
  logic        p1_valid_r;
  logic [1:0]  id_err_r, id_err_nxt;
  logic [rcv_pkg::MAP_ROWS-1:0] row_valid_r;
  logic        lw_valid_r;
  logic [MAP_AW-1:0] lw_addr_r;
  logic [rcv_pkg::MAP_ROW_BITS-1:0] lw_data_r;

  logic [rcv_pkg::MAP_ROW_BITS-1:0] ram_rdata;
  logic [rcv_pkg::MAP_ROW_BITS-1:0] cur_row;
  logic [rcv_pkg::MAP_ROW_BITS-1:0] new_row;
  logic        p1_fire;
  logic        map_we;
  rcv_pkg::status_t status1;

  // output register
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  rcv_pkg::kind_t   out_kind_r;
  logic        out_done_r;
  rcv_pkg::status_t out_status_r;

  assign adv      = !out_valid_r || out_stream.ready;
  // no transfer is taken while reset is asserted
  assign in_ready = rst_n && (!p1_valid_r || adv);
  assign accept   = in_stream.valid && in_ready;
  assign p1_fire  = p1_valid_r && adv;

  assign in_stream.ready = in_ready;

  // section boundaries from the header as received
  assign pos10 = {2'b00, byte_count_r};
  assign a0    = 10'(rcv_pkg::HDR_BYTES) + {2'b00, name_len_r};
  assign b0    = a0 + {2'b00, act_cnt_r};
  assign c0    = b0 + {2'b00, btn_cnt_r};

  assign hash_mul = (hash_r ^ {24'd0, tail_r[0]}) * rcv_pkg::FNV_PRIME;
  // the byte leaving the delay line enters the hash
  assign hash_upd = (byte_count_r >= 8'd4) ? hash_mul : hash_r;

  always_comb begin
    byte_count_nxt = byte_count_r;
    magic_bad_nxt  = magic_bad_r;
    version_nxt    = version_r;
    name_len_nxt   = name_len_r;
    act_cnt_nxt    = act_cnt_r;
    btn_cnt_nxt    = btn_cnt_r;
    hash_nxt       = hash_r;
    overlong_nxt   = overlong_r;
    tail_nxt       = tail_r;
    kind0          = rcv_pkg::KIND_TAIL;
    pre_status0    = rcv_pkg::ST_OK;
    stored0        = '0;
    expect_len     = '0;

    if (accept) begin
      if (byte_count_r == rcv_pkg::COUNT_MAX) begin
        overlong_nxt = 1'b1;
      end else begin
        if (byte_count_r < 8'd4) begin
          if (in_stream.data_byte != rcv_pkg::magic_byte(byte_count_r[1:0])) begin
            magic_bad_nxt = 1'b1;
          end
          kind0 = rcv_pkg::KIND_HDR;
        end else if (byte_count_r < 8'(rcv_pkg::HDR_BYTES)) begin
          unique case (byte_count_r[1:0])
            2'd0:    version_nxt  = in_stream.data_byte;
            2'd1:    name_len_nxt = in_stream.data_byte;
            2'd2:    act_cnt_nxt  = in_stream.data_byte;
            default: btn_cnt_nxt  = in_stream.data_byte;
          endcase
          kind0 = rcv_pkg::KIND_HDR;
        end else if (pos10 < a0) begin
          kind0 = rcv_pkg::KIND_NAME;
        end else if (pos10 < b0) begin
          kind0 = rcv_pkg::KIND_ACT;
        end else if (pos10 < c0) begin
          kind0 = rcv_pkg::KIND_BTN;
        end
        byte_count_nxt = byte_count_r + 8'd1;
      end

      hash_nxt    = hash_upd;
      tail_nxt[0] = tail_r[1];
      tail_nxt[1] = tail_r[2];
      tail_nxt[2] = tail_r[3];
      tail_nxt[3] = in_stream.data_byte;

      stored0    = {tail_nxt[3], tail_nxt[2], tail_nxt[1], tail_nxt[0]};
      expect_len = 10'(rcv_pkg::HDR_BYTES + rcv_pkg::SUM_BYTES) + {2'b00, name_len_nxt} +
                   {2'b00, act_cnt_nxt} + {2'b00, btn_cnt_nxt};

      priority if (overlong_nxt || {2'b00, byte_count_nxt} < 10'(rcv_pkg::MIN_LEN) ||
                   {2'b00, byte_count_nxt} > 10'(MAX_LEN)) begin
        pre_status0 = rcv_pkg::ST_LEN;
      end else if (magic_bad_nxt) begin
        pre_status0 = rcv_pkg::ST_MAGIC;
      end else if (version_nxt != rcv_pkg::REC_VERSION) begin
        pre_status0 = rcv_pkg::ST_VERSION;
      end else if (name_len_nxt == 8'd0 ||
                   name_len_nxt > 8'(MAX_NAME_BYTES)) begin
        pre_status0 = rcv_pkg::ST_NAME_LEN;
      end else if (act_cnt_nxt > 8'(MAX_ACTUATOR_IDS) ||
                   btn_cnt_nxt > 8'(MAX_BUTTON_IDS)) begin
        pre_status0 = rcv_pkg::ST_COUNT;
      end else if ({2'b00, byte_count_nxt} != expect_len) begin
        pre_status0 = rcv_pkg::ST_MISMATCH;
      end else begin
        pre_status0 = rcv_pkg::ST_OK;
      end

      if (in_stream.last_byte) begin
        byte_count_nxt = '0;
        magic_bad_nxt  = 1'b0;
        version_nxt    = '0;
        name_len_nxt   = '0;
        act_cnt_nxt    = '0;
        btn_cnt_nxt    = '0;
        hash_nxt       = rcv_pkg::FNV_BASIS;
        overlong_nxt   = 1'b0;
        tail_nxt[0]    = '0;
        tail_nxt[1]    = '0;
        tail_nxt[2]    = '0;
        tail_nxt[3]    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      magic_bad_r  <= 1'b0;
      version_r    <= '0;
      name_len_r   <= '0;
      act_cnt_r    <= '0;
      btn_cnt_r    <= '0;
      hash_r       <= rcv_pkg::FNV_BASIS;
      overlong_r   <= 1'b0;
      tail_r[0]    <= '0;
      tail_r[1]    <= '0;
      tail_r[2]    <= '0;
      tail_r[3]    <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      magic_bad_r  <= magic_bad_nxt;
      version_r    <= version_nxt;
      name_len_r   <= name_len_nxt;
      act_cnt_r    <= act_cnt_nxt;
      btn_cnt_r    <= btn_cnt_nxt;
      hash_r       <= hash_nxt;
      overlong_r   <= overlong_nxt;
      tail_r       <= tail_nxt;
    end
  end

  // stage 0 -> stage 1 payload; the hash goes over before the end-of-record clear
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_r.byte_value <= in_stream.data_byte;
      p1_r.kind       <= kind0;
      p1_r.last       <= in_stream.last_byte;
      p1_r.pre_status <= pre_status0;
      p1_r.hash       <= hash_upd;
      p1_r.stored     <= stored0;
      p1_r.is_id      <= (kind0 == rcv_pkg::KIND_ACT) || (kind0 == rcv_pkg::KIND_BTN);
      p1_r.row        <= {kind0 == rcv_pkg::KIND_BTN, in_stream.data_byte[7:BIT_AW]};
      p1_r.bit_sel    <= in_stream.data_byte[BIT_AW-1:0];
      p1_r.id_zero    <= in_stream.data_byte == 8'd0;
    end
  end

  rcv_ram #(
    .WIDTH (rcv_pkg::MAP_ROW_BITS),
    .DEPTH (rcv_pkg::MAP_ROWS)
  ) u_seen_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (p1_r.row),
    .wdata (new_row),
    .re    (accept),
    .raddr ({kind0 == rcv_pkg::KIND_BTN, in_stream.data_byte[7:BIT_AW]}),
    .rdata (ram_rdata)
  );

  // stage 1: seen-ID test and write back; last write forwarded, invalid rows read as empty
  always_comb begin
    priority if (lw_valid_r && lw_addr_r == p1_r.row) begin
      cur_row = lw_data_r;
    end else if (row_valid_r[p1_r.row]) begin
      cur_row = ram_rdata;
    end else begin
      cur_row = '0;
    end
    new_row              = cur_row;
    new_row[p1_r.bit_sel] = 1'b1;
    id_err_nxt           = id_err_r;
    map_we               = 1'b0;
    if (p1_fire && p1_r.is_id) begin
      priority if (p1_r.id_zero) begin
        id_err_nxt[0] = 1'b1;
      end else if (cur_row[p1_r.bit_sel]) begin
        id_err_nxt[1] = 1'b1;
      end else begin
        map_we = 1'b1;
      end
    end

    priority if (!p1_r.last) begin
      status1 = rcv_pkg::ST_OK;
    end else if (p1_r.pre_status != rcv_pkg::ST_OK) begin
      status1 = p1_r.pre_status;
    end else if (p1_r.stored != p1_r.hash) begin
      status1 = rcv_pkg::ST_CHECKSUM;
    end else if (id_err_nxt[0]) begin
      status1 = rcv_pkg::ST_ZERO_ID;
    end else if (id_err_nxt[1]) begin
      status1 = rcv_pkg::ST_DUP_ID;
    end else begin
      status1 = rcv_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      id_err_r    <= '0;
      row_valid_r <= '0;
      lw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        p1_valid_r <= 1'b1;
      end else if (adv) begin
        p1_valid_r <= 1'b0;
      end

      if (p1_fire && p1_r.last) begin
        id_err_r    <= '0;
        row_valid_r <= '0;
        lw_valid_r  <= 1'b0;
      end else begin
        id_err_r <= id_err_nxt;
        if (map_we) begin
          row_valid_r[p1_r.row] <= 1'b1;
          lw_valid_r            <= 1'b1;
        end
      end

      if (adv) begin
        out_valid_r <= p1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      lw_addr_r <= p1_r.row;
      lw_data_r <= new_row;
    end
    if (p1_fire) begin
      out_byte_r   <= p1_r.byte_value;
      out_kind_r   <= p1_r.kind;
      out_done_r   <= p1_r.last;
      out_status_r <= status1;
    end
  end

  assign out_stream.valid       = out_valid_r;
  assign out_stream.byte_value  = out_byte_r;
  assign out_stream.byte_kind   = out_kind_r;
  assign out_stream.record_done = out_done_r;
  assign out_stream.status      = out_status_r;

endmodule

// ===== tb/sv/tb_record_checksum_validator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_record_checksum_validator_unit
// Self-checking bench for the record validator. Builds records byte by byte,
// both well-formed and damaged in one chosen way. A small table walks the
// extremes and every status code. Random records follow, with random idle on
// both sides and one long receiver hold-off. Every result transfer is compared
// field by field against a byte-level model of tagging, hashing and status.
// ----------------------------------------------------------------------------
module tb_record_checksum_validator_unit;

  localparam int unsigned NAME_LIMIT   = 32;
  localparam int unsigned ACT_LIMIT    = 16;
  localparam int unsigned BTN_LIMIT    = 16;
  localparam int unsigned HEAD_LEN     = 8;
  localparam int unsigned SUM_LEN      = 4;
  localparam int unsigned LEN_MIN      = HEAD_LEN + SUM_LEN;
  localparam int unsigned LEN_MAX      = HEAD_LEN + NAME_LIMIT + ACT_LIMIT + BTN_LIMIT + SUM_LEN;
  localparam logic [7:0]  VERSION_OK   = 8'd2;
  localparam logic [31:0] HASH_SEED    = 32'h811C9DC5;
  localparam logic [31:0] HASH_MUL     = 32'h01000193;
  localparam logic [31:0] MAGIC_WORD   = "LSHD";

  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 1000;
  localparam int RANDOM_BYTES = 700;

  typedef enum logic [3:0] {
    FLAW_NONE,
    FLAW_SHORT,     // nlen copies of the version byte, nothing else
    FLAW_NOISE,
    FLAW_MAGIC,
    FLAW_SUM,
    FLAW_DROP,
    FLAW_EXTRA,
    FLAW_ZERO,
    FLAW_DUP,
    FLAW_ZERO_DUP,
    FLAW_CROSS,     // first button ID repeats the first actuator ID
    FLAW_OVERLONG
  } flaw_t;

  typedef struct packed {
    logic [7:0]       value;
    rcv_pkg::kind_t   kind;
    logic             done;
    rcv_pkg::status_t st;
  } byte_result_t;

  typedef struct packed {
    logic [7:0]       ver;
    logic [7:0]       nlen;
    logic [7:0]       acnt;
    logic [7:0]       bcnt;
    flaw_t            flaw;
    logic             typed;
    rcv_pkg::status_t st;
  } record_row_t;

  record_row_t plan [18] = '{
    '{8'hFF, 8'd1,   8'd0,  8'd0,  FLAW_SHORT,    1'b1, rcv_pkg::ST_LEN},
    '{8'h00, 8'd3,   8'd0,  8'd0,  FLAW_SHORT,    1'b1, rcv_pkg::ST_LEN},
    '{8'd2,  8'd1,   8'd0,  8'd0,  FLAW_NONE,     1'b1, rcv_pkg::ST_OK},
    '{8'd2,  8'd32,  8'd16, 8'd16, FLAW_NONE,     1'b1, rcv_pkg::ST_OK},
    '{8'd2,  8'd32,  8'd16, 8'd16, FLAW_EXTRA,    1'b1, rcv_pkg::ST_LEN},
    '{8'd2,  8'd255, 8'd0,  8'd0,  FLAW_NONE,     1'b1, rcv_pkg::ST_LEN},
    '{8'd2,  8'd1,   8'd0,  8'd0,  FLAW_MAGIC,    1'b1, rcv_pkg::ST_MAGIC},
    '{8'hFF, 8'd1,   8'd0,  8'd0,  FLAW_NONE,     1'b1, rcv_pkg::ST_VERSION},
    '{8'd2,  8'd0,   8'd0,  8'd0,  FLAW_NONE,     1'b1, rcv_pkg::ST_NAME_LEN},
    '{8'd2,  8'd33,  8'd0,  8'd0,  FLAW_NONE,     1'b1, rcv_pkg::ST_NAME_LEN},
    '{8'd2,  8'd1,   8'd17, 8'd0,  FLAW_NONE,     1'b1, rcv_pkg::ST_COUNT},
    '{8'd2,  8'd1,   8'd0,  8'd17, FLAW_NONE,     1'b1, rcv_pkg::ST_COUNT},
    '{8'd2,  8'd4,   8'd2,  8'd2,  FLAW_DROP,     1'b1, rcv_pkg::ST_MISMATCH},
    '{8'd2,  8'd4,   8'd2,  8'd2,  FLAW_SUM,      1'b1, rcv_pkg::ST_CHECKSUM},
    '{8'd2,  8'd4,   8'd2,  8'd2,  FLAW_ZERO,     1'b1, rcv_pkg::ST_ZERO_ID},
    '{8'd2,  8'd4,   8'd3,  8'd3,  FLAW_DUP,      1'b1, rcv_pkg::ST_DUP_ID},
    '{8'd2,  8'd4,   8'd2,  8'd2,  FLAW_ZERO_DUP, 1'b1, rcv_pkg::ST_ZERO_ID},
    '{8'd2,  8'd4,   8'd3,  8'd3,  FLAW_CROSS,    1'b1, rcv_pkg::ST_OK}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic rx_hold = 1'b0;
  logic rx_no_stalls = 1'b0;
  logic tx_no_gaps = 1'b0;

  rcv_in_if  in_bus ();
  rcv_out_if out_bus ();

  record_checksum_validator_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_bus),
    .out_stream (out_bus)
  );

  always #4 clk = ~clk;

  // model of the record state
  logic [7:0]      rec_count, rec_ver, rec_nlen, rec_acnt, rec_bcnt;
  logic            rec_magic_bad, rec_zero_id, rec_dup_id, rec_overlong;
  logic [31:0]     rec_hash;
  logic [3:0][7:0] rec_tail;  // [0] is the oldest byte
  logic [255:0]    act_seen, btn_seen;

  byte_result_t due_bytes [$];
  logic [7:0]   rec_bytes [$];

  int bytes_sent = 0;
  int records_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycles = 0;
  int st_hist [10];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch, result %0d, %s: got %0h want %0h",
             $time, results_seen, what, got, want);
  endtask

  function automatic void append_byte(input logic [7:0] b);
    rec_bytes = {rec_bytes, b};
  endfunction

  function automatic void clear_record_state();
    rec_count     = '0;
    rec_ver       = '0;
    rec_nlen      = '0;
    rec_acnt      = '0;
    rec_bcnt      = '0;
    rec_magic_bad = 1'b0;
    rec_zero_id   = 1'b0;
    rec_dup_id    = 1'b0;
    rec_overlong  = 1'b0;
    rec_hash      = HASH_SEED;
    rec_tail      = '0;
    act_seen      = '0;
    btn_seen      = '0;
  endfunction

  function automatic void note_id(input logic in_btn_list, input logic [7:0] id);
    logic hit;
    hit = in_btn_list ? btn_seen[id] : act_seen[id];
    if (id == 8'd0) rec_zero_id = 1'b1;
    else if (hit) rec_dup_id = 1'b1;
    else if (in_btn_list) btn_seen[id] = 1'b1;
    else act_seen[id] = 1'b1;
  endfunction

  // tags one byte, updates hash and ID maps, and settles the status on the last byte
  function automatic byte_result_t validate_byte(input logic [7:0] b, input logic last);
    byte_result_t r;
    int pos, a0, b0, c0, want_len;
    pos     = rec_count;
    r.value = b;
    r.kind  = rcv_pkg::KIND_TAIL;
    r.done  = last;
    r.st    = rcv_pkg::ST_OK;
    if (pos == 255) begin
      rec_overlong = 1'b1;
    end else begin
      if (pos < 4) begin
        if (b != MAGIC_WORD[31 - 8*pos -: 8]) rec_magic_bad = 1'b1;
        r.kind = rcv_pkg::KIND_HDR;
      end else if (pos < HEAD_LEN) begin
        case (pos)
          4:       rec_ver  = b;
          5:       rec_nlen = b;
          6:       rec_acnt = b;
          default: rec_bcnt = b;
        endcase
        r.kind = rcv_pkg::KIND_HDR;
      end else begin
        a0 = HEAD_LEN + rec_nlen;
        b0 = a0 + rec_acnt;
        c0 = b0 + rec_bcnt;
        if (pos < a0) begin
          r.kind = rcv_pkg::KIND_NAME;
        end else if (pos < b0) begin
          r.kind = rcv_pkg::KIND_ACT;
          note_id(1'b0, b);
        end else if (pos < c0) begin
          r.kind = rcv_pkg::KIND_BTN;
          note_id(1'b1, b);
        end
      end
      rec_count = rec_count + 8'd1;
    end
    // the byte leaving the four-byte delay enters the hash
    if (pos >= 4) rec_hash = (rec_hash ^ {24'd0, rec_tail[0]}) * HASH_MUL;
    rec_tail = {b, rec_tail[3:1]};
    if (last) begin
      want_len = HEAD_LEN + rec_nlen + rec_acnt + rec_bcnt + SUM_LEN;
      if (rec_overlong || rec_count < LEN_MIN || rec_count > LEN_MAX) r.st = rcv_pkg::ST_LEN;
      else if (rec_magic_bad) r.st = rcv_pkg::ST_MAGIC;
      else if (rec_ver != VERSION_OK) r.st = rcv_pkg::ST_VERSION;
      else if (rec_nlen == 0 || rec_nlen > NAME_LIMIT) r.st = rcv_pkg::ST_NAME_LEN;
      else if (rec_acnt > ACT_LIMIT || rec_bcnt > BTN_LIMIT) r.st = rcv_pkg::ST_COUNT;
      else if (rec_count != want_len) r.st = rcv_pkg::ST_MISMATCH;
      else if (rec_tail != rec_hash) r.st = rcv_pkg::ST_CHECKSUM;
      else if (rec_zero_id) r.st = rcv_pkg::ST_ZERO_ID;
      else if (rec_dup_id) r.st = rcv_pkg::ST_DUP_ID;
      clear_record_state();
    end
    return r;
  endfunction

  task automatic build_record(input record_row_t r);
    logic [255:0] used;
    logic [31:0]  h;
    logic [7:0]   id;
    int           k, a0, b0, c0, pick, target;
    rec_bytes.delete();
    a0 = HEAD_LEN + r.nlen;
    b0 = a0 + r.acnt;
    c0 = b0 + r.bcnt;
    if (r.flaw == FLAW_SHORT) begin
      repeat (r.nlen) append_byte(r.ver);
    end else if (r.flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 48)) append_byte(8'($urandom));
    end else begin
      for (k = 0; k < 4; k++) append_byte(MAGIC_WORD[31 - 8*k -: 8]);
      if (r.flaw == FLAW_MAGIC) begin
        pick = $urandom_range(0, 3);
        rec_bytes[pick] = rec_bytes[pick] ^ 8'($urandom_range(1, 255));
      end
      append_byte(r.ver);
      append_byte(r.nlen);
      append_byte(r.acnt);
      append_byte(r.bcnt);
      repeat (r.nlen) append_byte(8'($urandom));
      used = '0;
      for (k = 0; k < r.acnt; k++) begin
        do id = 8'($urandom_range(1, 255)); while (used[id]);
        used[id] = 1'b1;
        append_byte(id);
      end
      used = '0;
      for (k = 0; k < r.bcnt; k++) begin
        if (r.flaw == FLAW_CROSS && k == 0 && r.acnt != 0) begin
          id = rec_bytes[a0];
        end else begin
          do id = 8'($urandom_range(1, 255)); while (used[id]);
        end
        used[id] = 1'b1;
        append_byte(id);
      end
      if (r.flaw == FLAW_DUP || r.flaw == FLAW_ZERO_DUP) begin
        if (r.acnt >= 2) rec_bytes[a0 + 1] = rec_bytes[a0];
        else if (r.bcnt >= 2) rec_bytes[b0 + 1] = rec_bytes[b0];
      end
      if ((r.flaw == FLAW_ZERO || r.flaw == FLAW_ZERO_DUP) && c0 > a0)
        rec_bytes[$urandom_range(a0, c0 - 1)] = 8'd0;
      h = HASH_SEED;
      for (k = 0; k < rec_bytes.size(); k++) h = (h ^ {24'd0, rec_bytes[k]}) * HASH_MUL;
      for (k = 0; k < 4; k++) append_byte(h[8*k +: 8]);
      if (r.flaw == FLAW_SUM) begin
        pick = rec_bytes.size() - 1 - $urandom_range(0, 3);
        rec_bytes[pick] = rec_bytes[pick] ^ 8'(1 << $urandom_range(0, 7));
      end
      if (r.flaw == FLAW_DROP)
        rec_bytes.delete($urandom_range(HEAD_LEN, rec_bytes.size() - 1));
      if (r.flaw == FLAW_EXTRA)
        rec_bytes.insert($urandom_range(HEAD_LEN, rec_bytes.size()), 8'($urandom));
      if (r.flaw == FLAW_OVERLONG) begin
        target = $urandom_range(256, 300);
        while (rec_bytes.size() < target) append_byte(8'($urandom));
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input rcv_pkg::status_t st);
    byte_result_t want;
    int gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= last;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    want = validate_byte(b, last);
    if (last && typed) want.st = st;
    if (last) begin
      st_hist[want.st]++;
      records_sent++;
    end
    due_bytes = {due_bytes, want};
    bytes_sent++;
  endtask

  task automatic send_record(input logic typed, input rcv_pkg::status_t st);
    int k;
    tx_no_gaps = ($urandom_range(0, 4) == 0);
    for (k = 0; k < rec_bytes.size(); k++)
      send_byte(rec_bytes[k], k == rec_bytes.size() - 1, typed, st);
  endtask

  initial begin : stimulus
    record_row_t r;
    int          i, pick, random_bytes;
    string       mix;
    random_bytes = 0;
    foreach (st_hist[i]) st_hist[i] = 0;
    in_bus.valid     <= 1'b0;
    in_bus.data_byte <= '0;
    in_bus.last_byte <= 1'b0;
    rst_n            <= 1'b0;
    clear_record_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < $size(plan); i++) begin
      build_record(plan[i]);
      send_record(plan[i].typed, plan[i].st);
    end

    // a mix of well-formed records and records that carry one defect each
    while (random_bytes < RANDOM_BYTES) begin
      r.ver   = VERSION_OK;
      r.flaw  = FLAW_NONE;
      r.typed = 1'b0;
      r.st    = rcv_pkg::ST_OK;
      r.nlen  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, NAME_LIMIT))
                                            : 8'($urandom_range(1, 6));
      r.acnt  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, ACT_LIMIT))
                                            : 8'($urandom_range(0, 4));
      r.bcnt  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, BTN_LIMIT))
                                            : 8'($urandom_range(0, 4));
      pick = $urandom_range(0, 99);
      if (pick < 45) r.flaw = FLAW_NONE;
      else if (pick < 52) r.flaw = FLAW_MAGIC;
      else if (pick < 56) r.ver = 8'($urandom);
      else if (pick < 60) begin
        r.nlen = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(NAME_LIMIT + 1, 60));
      end else if (pick < 64) begin
        if ($urandom_range(0, 1) == 0) r.acnt = 8'($urandom_range(ACT_LIMIT + 1, 40));
        else r.bcnt = 8'($urandom_range(BTN_LIMIT + 1, 40));
      end
      else if (pick < 68) r.flaw = FLAW_DROP;
      else if (pick < 72) r.flaw = FLAW_EXTRA;
      else if (pick < 77) r.flaw = FLAW_SUM;
      else if (pick < 82) r.flaw = FLAW_ZERO;
      else if (pick < 86) r.flaw = FLAW_DUP;
      else if (pick < 88) r.flaw = FLAW_ZERO_DUP;
      else if (pick < 90) r.flaw = FLAW_CROSS;
      else if (pick < 96) r.flaw = FLAW_NOISE;
      else if (pick < 99) begin
        r.flaw = FLAW_SHORT;
        r.ver  = 8'($urandom);
        r.nlen = 8'($urandom_range(1, LEN_MIN - 1));
      end
      else r.flaw = FLAW_OVERLONG;
      build_record(r);
      send_record(r.typed, r.st);
      random_bytes += rec_bytes.size();
    end
    in_bus.valid <= 1'b0;

    while (due_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    mix = "";
    foreach (st_hist[i]) mix = {mix, $sformatf(" %0d:%0d", i, st_hist[i])};
    $display("Covered %0d records, %0d bytes, %0d results compared, one %0d-cycle hold-off",
             records_sent, bytes_sent, results_seen, HOLD_CYCLES);
    $display("Records per status code:%s", mix);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // long receiver hold-off so the pipeline backs up into the input
  initial begin : rx_pressure
    wait (bytes_sent >= HOLD_AFTER);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : result_sink
    byte_result_t want;
    int           stall;
    out_bus.ready <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_no_stalls = !rx_no_stalls;
      stall = rx_no_stalls ? 0 : $urandom_range(0, 19);
      if (stall != 0 || rx_hold) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      results_seen++;
      if (due_bytes.size() == 0) begin
        report_mismatch("transfer with nothing pending", 32'(out_bus.byte_value), 32'd0);
      end else begin
        want = due_bytes.pop_front();
        if (out_bus.byte_value !== want.value)
          report_mismatch("byte_value", 32'(out_bus.byte_value), 32'(want.value));
        if (out_bus.byte_kind !== want.kind)
          report_mismatch("byte_kind", 32'(out_bus.byte_kind), 32'(want.kind));
        if (out_bus.record_done !== want.done)
          report_mismatch("record_done", 32'(out_bus.record_done), 32'(want.done));
        if (out_bus.status !== want.st)
          report_mismatch("status", 32'(out_bus.status), 32'(want.st));
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results still pending", cycles, due_bytes.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
